>>> src/vbi_pkg.sv
`default_nettype none
package vbi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DtW    = 16;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_ADD    = 2'd1,
    OP_ACCEL  = 2'd2,
    OP_INERT  = 2'd3
  } opcode_e;

  localparam logic signed [CoordW-1:0] GravityQ16 = -32'sd642689;
  localparam logic signed [CoordW-1:0] SatMax = 32'sh7fffffff;
  localparam logic signed [CoordW-1:0] SatMin = 32'sh80000000;

  // One classified command as it travels from the front part to the back part.
  typedef struct packed {
    opcode_e                    op;
    logic                       reject;
    logic                       grav;
    logic [15:0]                body;
    logic signed [CoordW-1:0]   vx;
    logic signed [CoordW-1:0]   vy;
    logic signed [CoordW-1:0]   vz;
    logic [DtW-1:0]             dt2;
  } cmd_t;

  // Saturate a 34-bit signed sum into 32 bits.
  function automatic logic signed [CoordW-1:0] sat34(input logic signed [33:0] v);
    logic signed [CoordW-1:0] r;
    r = v[CoordW-1:0];
    if (v > 34'sh0_7fffffff) r = SatMax;
    else if (v < -34'sh0_80000000) r = SatMin;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/vbi_front.sv
`default_nettype none
// Front part: looks the body up in the flag memory, updates the flags,
// squares dt and hands a classified command to the back part.
module vbi_front #(
  parameter int unsigned MaxBodies = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    op_i,
  input  wire logic [9:0]    body_i,
  input  wire logic [31:0]   vx_i,
  input  wire logic [31:0]   vy_i,
  input  wire logic [31:0]   vz_i,
  input  wire logic          grav_i,
  input  wire logic [15:0]   dt_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output vbi_pkg::cmd_t      cmd_o
);
  import vbi_pkg::*;

  localparam int unsigned FlagDepth = (MaxBodies > 1024) ? 1024 : MaxBodies;
  localparam int unsigned FIdxW = (FlagDepth > 1) ? $clog2(FlagDepth) : 1;
  localparam int unsigned LiveBit = 0;
  localparam int unsigned GravBit = 1;
  localparam logic [1:0] S_CLR = 2'd0, S_IDLE = 2'd1, S_LOOK = 2'd2, S_HOLD = 2'd3;

  logic [1:0]           flag_mem [FlagDepth];
  logic [1:0]           flag_rd_q;
  logic [1:0]           st_q;
  logic [FIdxW-1:0]     clr_q;
  logic                 range_q;
  cmd_t                 cmd_q;
  logic                 in_range;
  logic                 creating;
  logic                 flag_we;
  logic [1:0]           flag_wd;
  logic [FIdxW-1:0]     fidx;
  logic [FIdxW-1:0]     widx;
  logic [31:0]          dtsq;

  assign fidx     = FIdxW'(body_i);
  assign widx     = (st_q == S_CLR) ? clr_q : FIdxW'(cmd_q.body);
  assign in_range = (body_i != 10'd0) && (32'(body_i) < MaxBodies);
  assign creating = (cmd_q.op == OP_CREATE);
  assign flag_we  = (st_q == S_CLR) || (st_q == S_LOOK && creating && range_q);
  assign flag_wd  = (st_q == S_CLR) ? 2'b00 : {cmd_q.grav, 1'b1};
  assign dtsq     = 32'(dt_i) * 32'(dt_i) + 32'd32768;

  assign in_ready_o  = (st_q == S_IDLE);
  assign cmd_valid_o = (st_q == S_HOLD);
  assign cmd_o       = cmd_q;

  // Flag memory: bit 0 marks a created body, bit 1 its gravity flag.
  always_ff @(posedge clk_i) begin
    if (flag_we) flag_mem[widx] <= flag_wd;
    if (in_valid_i && in_ready_o) flag_rd_q <= flag_mem[fidx];
  end

  // Sequencer: clearing pass after reset, then accept, look up and hand over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLR;
      clr_q <= '0;
    end else begin
      unique case (st_q)
        S_CLR: begin
          clr_q <= clr_q + FIdxW'(1);
          if (clr_q == FIdxW'(FlagDepth - 1)) st_q <= S_IDLE;
        end
        S_IDLE: if (in_valid_i) st_q <= S_LOOK;
        S_LOOK: st_q <= S_HOLD;
        default: if (cmd_ready_i) st_q <= S_IDLE;
      endcase
    end
  end

  // Classified command.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q.op   <= opcode_e'(op_i);
      cmd_q.grav <= grav_i;
      cmd_q.body <= 16'(body_i);
      cmd_q.vx   <= vx_i;
      cmd_q.vy   <= vy_i;
      cmd_q.vz   <= vz_i;
      cmd_q.dt2  <= dtsq[31:16];
      range_q    <= in_range;
    end
    if (st_q == S_LOOK) begin
      cmd_q.reject <= !range_q || (!creating && !flag_rd_q[LiveBit]);
      if (!creating) cmd_q.grav <= flag_rd_q[GravBit];
    end
  end

endmodule
`default_nettype wire

>>> src/vbi_back.sv
`default_nettype none
// Back part: reads the body's stores, works the axes one after the other and
// writes back, then presents the new position; rejected commands skip the axes.
module vbi_back #(
  parameter int unsigned MaxBodies = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  vbi_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        px_o,
  output logic [31:0]        py_o,
  output logic [31:0]        pz_o,
  output logic               rej_o
);
  import vbi_pkg::*;

  localparam int unsigned Depth = (MaxBodies > 1024) ? 1024 : MaxBodies;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_EX = 3'd2,
                         S_WR = 3'd3, S_OUT = 3'd4;

  logic signed [31:0] pos_mem [3][Depth];
  logic signed [31:0] prv_mem [3][Depth];
  logic signed [31:0] acc_mem [3][Depth];

  logic [2:0]         st_q;
  logic [1:0]         ax_q;
  cmd_t               c_q;
  logic signed [31:0] pos_r, prv_r, acc_r;
  logic signed [31:0] res_q, prvw_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic               rej_q;
  logic [AW-1:0]      a;
  logic signed [31:0] vsel, accg, nres;
  logic signed [48:0] prod;
  logic signed [32:0] dx;

  assign a = AW'(c_q.body);
  assign cmd_ready_o = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign px_o = px_q;
  assign py_o = py_q;
  assign pz_o = pz_q;
  assign rej_o = rej_q;

  always_comb begin
    unique case (ax_q)
      2'd0:    vsel = c_q.vx;
      2'd1:    vsel = c_q.vy;
      default: vsel = c_q.vz;
    endcase
  end

  // Arithmetic of one axis.
  always_comb begin
    accg = acc_r;
    if (c_q.grav && ax_q == 2'd1) accg = sat34(34'(acc_r) + 34'(GravityQ16));
    prod = accg * $signed({1'b0, c_q.dt2}) + 49'sd32768;
    dx   = prod[48:16];
    unique case (c_q.op)
      OP_CREATE: nres = vsel;
      OP_ADD:    nres = sat34(34'(acc_r) + 34'(vsel));
      OP_ACCEL:  nres = sat34(34'(pos_r) + 34'(dx));
      default:   nres = sat34((34'(pos_r) <<< 1) - 34'(prv_r));
    endcase
  end

  // Store reads, registered.
  always_ff @(posedge clk_i) begin
    pos_r <= pos_mem[ax_q][a];
    prv_r <= prv_mem[ax_q][a];
    acc_r <= acc_mem[ax_q][a];
  end

  // Store writes.
  always_ff @(posedge clk_i) begin
    if (st_q == S_WR && !c_q.reject) begin
      unique case (c_q.op)
        OP_CREATE: begin
          pos_mem[ax_q][a] <= res_q;
          prv_mem[ax_q][a] <= res_q;
          acc_mem[ax_q][a] <= '0;
        end
        OP_ADD:   acc_mem[ax_q][a] <= res_q;
        OP_ACCEL: begin
          pos_mem[ax_q][a] <= res_q;
          acc_mem[ax_q][a] <= '0;
        end
        default: begin
          pos_mem[ax_q][a] <= res_q;
          prv_mem[ax_q][a] <= prvw_q;
        end
      endcase
    end
  end

  // Sequencer over the three axes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ax_q <= 2'd0;
    end else begin
      unique case (st_q)
        S_IDLE: if (cmd_valid_i) begin
          ax_q <= 2'd0;
          st_q <= cmd_i.reject ? S_OUT : S_RD;
        end
        S_RD: st_q <= S_EX;
        S_EX: st_q <= S_WR;
        S_WR: begin
          if (ax_q == 2'd2) st_q <= S_OUT;
          else begin
            ax_q <= ax_q + 2'd1;
            st_q <= S_RD;
          end
        end
        S_OUT: if (out_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && cmd_valid_i) begin
      c_q   <= cmd_i;
      rej_q <= cmd_i.reject;
      px_q  <= '0;
      py_q  <= '0;
      pz_q  <= '0;
    end
    if (st_q == S_EX) begin
      res_q  <= nres;
      prvw_q <= pos_r;
    end
    if (st_q == S_WR) begin
      unique case (ax_q)
        2'd0:    px_q <= (c_q.op == OP_ADD) ? pos_r : res_q;
        2'd1:    py_q <= (c_q.op == OP_ADD) ? pos_r : res_q;
        default: pz_q <= (c_q.op == OP_ADD) ? pos_r : res_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rej_o |-> px_o == '0 && py_o == '0 && pz_o == '0)
    else $error("rejected word carries a position");
  a_ax_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ax_q != 2'd3) else $error("axis counter out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
`endif

endmodule
`default_nettype wire

>>> src/verlet_body_integrator.sv
`default_nettype none
// Verlet body integrator.
// Slave channel s_axis_*: one word per command (opcode, body, vector,
// gravity flag, dt). Master channel m_axis_*: one word per command, the
// body's position after the command, with tuser set if it was rejected.
// The front part takes a word, reads the body's flags from the registered
// flag memory, classifies the command and then offers it to the back part.
// The back part runs the three axes one after the other over single-port
// store memories, each axis in a read, a compute and a write state, and
// then offers the result; a rejected word goes straight to the result.
// The front takes the next word while the back works. After reset the front
// clears the flag memory one entry a cycle, with s_axis_tready low; then no
// body exists. When the receiver stalls the result holds, the front keeps
// one command waiting and s_axis_tready stays low until the result is taken.
module verlet_body_integrator #(
  parameter int unsigned MAX_BODIES = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: opcode[1:0], body[11:2], vec_x[43:12], vec_y[75:44], vec_z[107:76],
  // time_step[123:108], zero fill
  input  wire logic [127:0] s_axis_tdata,
  // tuser: gravity_on
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64]
  output logic [95:0]       m_axis_tdata,
  // tuser: rejected
  output logic              m_axis_tuser
);
  import vbi_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  vbi_front #(.MaxBodies(MAX_BODIES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .op_i(s_axis_tdata[1:0]), .body_i(s_axis_tdata[11:2]),
    .vx_i(s_axis_tdata[43:12]), .vy_i(s_axis_tdata[75:44]),
    .vz_i(s_axis_tdata[107:76]), .grav_i(s_axis_tuser),
    .dt_i(s_axis_tdata[123:108]),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  vbi_back #(.MaxBodies(MAX_BODIES)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .px_o(m_axis_tdata[31:0]), .py_o(m_axis_tdata[63:32]),
    .pz_o(m_axis_tdata[95:64]), .rej_o(m_axis_tuser)
  );

endmodule
`default_nettype wire
